@@ rtl/orsm_pkg.sv @@
// Shared types and constants for the offline range-sum unit.
// Holds the input and result transfer structs; no dependencies.
package orsm_pkg;

    localparam int IDX_W = 10;
    localparam int VAL_W = 32;
    localparam int QNUM_W = 6;

    localparam logic FUNC_ELEMENT = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    typedef struct packed {
        logic                     func;
        logic signed [VAL_W-1:0]  value;
        logic [IDX_W-1:0]         left_index;
        logic [IDX_W-1:0]         right_index;
        logic                     batch_end;
    } t_in;

    typedef struct packed {
        logic [QNUM_W-1:0]        query_number;
        logic signed [VAL_W-1:0]  range_sum;
        logic                     invalid;
        logic                     final_answer;
    } t_out;

endpackage

@@ rtl/orsm_ram.sv @@
// Simple dual-port memory: one write port, one registered read port.
// Generic storage used by the range-sum unit; no package dependency.
module orsm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    parameter int AW = 6
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ rtl/orsm_div.sv @@
// Restoring divider, one quotient bit per cycle, for the query block number.
// Uses orsm_pkg for the index width.
module orsm_div #(
    parameter int DW = 6
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [orsm_pkg::IDX_W-1:0]  i_dividend,
    input  logic [DW-1:0]               i_divisor,
    output logic                        o_done,
    output logic [orsm_pkg::IDX_W-1:0]  o_quot
);
    import orsm_pkg::*;

    localparam int CNT_W = $clog2(IDX_W + 1);

    logic [IDX_W-1:0] r_num;
    logic [DW-1:0]    r_rem;
    logic [DW-1:0]    r_div;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [DW:0]      shifted;
    logic             fits;

    assign shifted = {r_rem[DW-1:0], r_num[IDX_W-1]};
    assign fits = shifted >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt <= '0;
                r_num <= i_dividend;
                r_rem <= '0;
                r_div <= i_divisor;
            end else if (r_busy) begin
                r_rem <= fits ? DW'(shifted - {1'b0, r_div}) : shifted[DW-1:0];
                r_num <= {r_num[IDX_W-2:0], fits};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(IDX_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_num;

endmodule

@@ rtl/offline_range_sum_mo_order_unit.sv @@
// Top level of the offline range-sum unit with block-ordered window walk.
// Depends on orsm_pkg, orsm_ram and orsm_div.
//
// Usage: the input channel carries one transfer per array element
// (func = element) or per range query (func = query). A query with
// batch_end set starts the batch: the unit raises o_in_stall, takes the
// integer square root of the element count (one result bit per cycle on
// a small multiplier), divides every query left bound by it on the
// serial divider, then picks queries in (block, right, arrival) order by
// scanning every stored key in the key memory for each visited query and
// slides the window through S_WSEL and S_WACC for each element that
// enters or leaves it. The data-dependent total is set by the window
// walk and the scans. Results then leave in arrival order, one transfer
// per stored query, each read, shown and held before the next is read;
// the last carries final_answer. While the receiver holds i_out_stall
// the result stays on o_out unchanged. After the last result the counts
// and the window clear and loading resumes. Synchronous active-low reset
// returns the unit to loading with empty counts; memory contents are
// left as they are.
module offline_range_sum_mo_order_unit #(
    parameter int MAX_ELEMENTS = 1024,
    parameter int MAX_QUERIES = 64
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  orsm_pkg::t_in  i_in,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output orsm_pkg::t_out o_out
);
    import orsm_pkg::*;

    // Element count, window pointer and address widths.
    localparam int CW = $clog2(MAX_ELEMENTS + 1);
    localparam int AW = $clog2(MAX_ELEMENTS);
    localparam int PW = (CW > IDX_W + 1) ? CW : IDX_W + 1;
    localparam int SW = (CW + 1) / 2;
    // Query count and index widths.
    localparam int QCW = $clog2(MAX_QUERIES + 1);
    localparam int QIW = (MAX_QUERIES > 1) ? $clog2(MAX_QUERIES) : 1;
    // Key memory entry: valid, block number, right, left.
    localparam int KMW = 1 + 3 * IDX_W;
    localparam int KEYW = 2 * IDX_W + QIW;
    localparam int ANSW = VAL_W + 1;

    typedef enum logic [3:0] {
        S_LOAD, S_SQRT, S_PRD, S_PST, S_PWT, S_SRD, S_SCMP,
        S_WSEL, S_WACC, S_ORD, S_OSH, S_OWT
    } t_state;

    t_state r_state;

    logic [CW-1:0]    r_ecnt;
    logic [QCW-1:0]   r_qcnt;
    logic [SW-1:0]    r_root;
    logic [SW-1:0]    r_mask;
    logic [SW-1:0]    r_blk;
    logic [QCW-1:0]   r_q;
    logic             r_have_prev;
    logic [KEYW-1:0]  r_prev;
    logic             r_found;
    logic [KEYW-1:0]  r_best;
    logic [IDX_W-1:0] r_best_left;
    logic [PW-1:0]    r_wl;
    logic [PW-1:0]    r_wr;
    logic [PW-1:0]    r_tl;
    logic [PW-1:0]    r_tr1;
    logic [QIW-1:0]   r_tidx;
    logic             r_add;
    logic [VAL_W-1:0] r_sum;
    logic             r_out_valid;
    t_out             r_out;

    logic [SW-1:0]    trial;
    logic [2*SW-1:0]  trial_sq;
    logic             accept_in;

    // Memory ports.
    logic             e_we, e_re;
    logic [AW-1:0]    e_waddr, e_raddr;
    logic [VAL_W-1:0] e_rdata;
    logic             q_we;
    logic [2*IDX_W-1:0] q_rdata;
    logic             k_we;
    logic [KMW-1:0]   k_wdata, k_rdata;
    logic             a_we, a_re;
    logic [QIW-1:0]   a_waddr;
    logic [ANSW-1:0]  a_wdata, a_rdata;

    // Divider.
    logic             div_start, div_done;
    logic [IDX_W-1:0] div_quot;

    // Prep and scan helpers.
    logic [IDX_W-1:0] p_left, p_right;
    logic             p_valid;
    logic [KEYW-1:0]  s_key;
    logic             s_cand, s_found, s_last;
    logic [KEYW-1:0]  s_best;
    logic [IDX_W-1:0] s_best_left;

    assign accept_in = i_in_valid && (r_state == S_LOAD);
    assign o_in_stall = (r_state != S_LOAD);

    assign trial = r_root | r_mask;
    assign trial_sq = trial * trial;

    // Query prep: the stored bounds are checked and divided.
    assign p_left = q_rdata[2*IDX_W-1:IDX_W];
    assign p_right = q_rdata[IDX_W-1:0];
    assign p_valid = (p_left <= p_right) && (PW'(p_right) < PW'(r_ecnt));

    // Scan: find the smallest key above the last visited one.
    assign s_key = {k_rdata[3*IDX_W-1:IDX_W], r_q[QIW-1:0]};
    assign s_cand = k_rdata[KMW-1] && (!r_have_prev || s_key > r_prev)
        && (!r_found || s_key < r_best);
    assign s_found = r_found || s_cand;
    assign s_best = s_cand ? s_key : r_best;
    assign s_best_left = s_cand ? k_rdata[IDX_W-1:0] : r_best_left;
    assign s_last = (r_q + 1'b1) == r_qcnt;

    // Element memory: written on loads, read during the window walk.
    assign e_we = accept_in && (i_in.func == FUNC_ELEMENT)
        && (r_ecnt < CW'(MAX_ELEMENTS));
    assign e_waddr = r_ecnt[AW-1:0];

    always_comb begin
        e_re = 1'b0;
        e_raddr = r_wl[AW-1:0];
        if (r_state == S_WSEL) begin
            priority if (r_wl < r_tl) begin
                e_re = 1'b1;
                e_raddr = r_wl[AW-1:0];
            end else if (r_wl > r_tl) begin
                e_re = 1'b1;
                e_raddr = AW'(r_wl - 1'b1);
            end else if (r_wr < r_tr1) begin
                e_re = 1'b1;
                e_raddr = r_wr[AW-1:0];
            end else if (r_wr > r_tr1) begin
                e_re = 1'b1;
                e_raddr = AW'(r_wr - 1'b1);
            end
        end
    end

    assign q_we = accept_in && (i_in.func == FUNC_QUERY)
        && (r_qcnt < QCW'(MAX_QUERIES));

    assign div_start = (r_state == S_PST);
    assign k_we = (r_state == S_PWT) && div_done;
    assign k_wdata = {p_valid, div_quot, p_right, p_left};

    // Answer memory: invalid queries during prep, sums after each walk.
    always_comb begin
        a_we = 1'b0;
        a_waddr = r_q[QIW-1:0];
        a_wdata = {1'b1, {VAL_W{1'b0}}};
        if (k_we && !p_valid) begin
            a_we = 1'b1;
        end else if ((r_state == S_WSEL) && !e_re) begin
            a_we = 1'b1;
            a_waddr = r_tidx;
            a_wdata = {1'b0, r_sum};
        end
    end
    assign a_re = (r_state == S_ORD);

    orsm_ram #(.WIDTH(VAL_W), .DEPTH(MAX_ELEMENTS), .AW(AW)) u_elem (
        .i_clk(i_clk), .i_wr_en(e_we), .i_wr_addr(e_waddr),
        .i_wr_data(i_in.value), .i_rd_en(e_re), .i_rd_addr(e_raddr),
        .o_rd_data(e_rdata)
    );

    orsm_ram #(.WIDTH(2 * IDX_W), .DEPTH(MAX_QUERIES), .AW(QIW)) u_query (
        .i_clk(i_clk), .i_wr_en(q_we), .i_wr_addr(r_qcnt[QIW-1:0]),
        .i_wr_data({i_in.left_index, i_in.right_index}),
        .i_rd_en(r_state == S_PRD), .i_rd_addr(r_q[QIW-1:0]),
        .o_rd_data(q_rdata)
    );

    orsm_ram #(.WIDTH(KMW), .DEPTH(MAX_QUERIES), .AW(QIW)) u_key (
        .i_clk(i_clk), .i_wr_en(k_we), .i_wr_addr(r_q[QIW-1:0]),
        .i_wr_data(k_wdata), .i_rd_en(r_state == S_SRD),
        .i_rd_addr(r_q[QIW-1:0]), .o_rd_data(k_rdata)
    );

    orsm_ram #(.WIDTH(ANSW), .DEPTH(MAX_QUERIES), .AW(QIW)) u_ans (
        .i_clk(i_clk), .i_wr_en(a_we), .i_wr_addr(a_waddr),
        .i_wr_data(a_wdata), .i_rd_en(a_re), .i_rd_addr(r_q[QIW-1:0]),
        .o_rd_data(a_rdata)
    );

    orsm_div #(.DW(SW)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
        .i_dividend(p_left), .i_divisor(r_blk),
        .o_done(div_done), .o_quot(div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_ecnt <= '0;
            r_qcnt <= '0;
            r_wl <= '0;
            r_wr <= '0;
            r_sum <= '0;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_LOAD: begin
                    if (e_we) begin
                        r_ecnt <= r_ecnt + 1'b1;
                    end
                    if (q_we) begin
                        r_qcnt <= r_qcnt + 1'b1;
                    end
                    if (accept_in && (i_in.func == FUNC_QUERY) && i_in.batch_end) begin
                        r_state <= S_SQRT;
                        r_root <= '0;
                        r_mask <= {1'b1, {(SW-1){1'b0}}};
                    end
                end
                S_SQRT: begin
                    if ((2*SW+PW)'(trial_sq) <= (2*SW+PW)'(r_ecnt)) begin
                        r_root <= trial;
                    end
                    r_mask <= r_mask >> 1;
                    if (r_mask[0]) begin
                        // Block size is the square root, with an empty array taken as one.
                        if ((2*SW+PW)'(trial_sq) <= (2*SW+PW)'(r_ecnt)) begin
                            r_blk <= trial;
                        end else if (r_root == '0) begin
                            r_blk <= SW'(1);
                        end else begin
                            r_blk <= r_root;
                        end
                        r_q <= '0;
                        r_state <= S_PRD;
                    end
                end
                S_PRD: r_state <= S_PST;
                S_PST: r_state <= S_PWT;
                S_PWT: begin
                    if (div_done) begin
                        if (s_last) begin
                            r_q <= '0;
                            r_have_prev <= 1'b0;
                            r_found <= 1'b0;
                            r_state <= S_SRD;
                        end else begin
                            r_q <= r_q + 1'b1;
                            r_state <= S_PRD;
                        end
                    end
                end
                S_SRD: r_state <= S_SCMP;
                S_SCMP: begin
                    r_found <= s_found;
                    r_best <= s_best;
                    r_best_left <= s_best_left;
                    if (s_last) begin
                        if (s_found) begin
                            r_prev <= s_best;
                            r_have_prev <= 1'b1;
                            r_tl <= PW'(s_best_left);
                            r_tr1 <= PW'(s_best[KEYW-IDX_W-1:QIW]) + 1'b1;
                            r_tidx <= s_best[QIW-1:0];
                            r_state <= S_WSEL;
                        end else begin
                            r_q <= '0;
                            r_state <= S_ORD;
                        end
                    end else begin
                        r_q <= r_q + 1'b1;
                        r_state <= S_SRD;
                    end
                end
                S_WSEL: begin
                    priority if (r_wl < r_tl) begin
                        r_add <= 1'b0;
                        r_wl <= r_wl + 1'b1;
                        r_state <= S_WACC;
                    end else if (r_wl > r_tl) begin
                        r_add <= 1'b1;
                        r_wl <= r_wl - 1'b1;
                        r_state <= S_WACC;
                    end else if (r_wr < r_tr1) begin
                        r_add <= 1'b1;
                        r_wr <= r_wr + 1'b1;
                        r_state <= S_WACC;
                    end else if (r_wr > r_tr1) begin
                        r_add <= 1'b0;
                        r_wr <= r_wr - 1'b1;
                        r_state <= S_WACC;
                    end else begin
                        // Window matches the query: its sum was written above.
                        r_q <= '0;
                        r_found <= 1'b0;
                        r_state <= S_SRD;
                    end
                end
                S_WACC: begin
                    r_sum <= r_add ? (r_sum + e_rdata) : (r_sum - e_rdata);
                    r_state <= S_WSEL;
                end
                S_ORD: r_state <= S_OSH;
                S_OSH: begin
                    r_out.query_number <= QNUM_W'(r_q[QIW-1:0]);
                    r_out.range_sum <= a_rdata[VAL_W-1:0];
                    r_out.invalid <= a_rdata[VAL_W];
                    r_out.final_answer <= s_last;
                    r_out_valid <= 1'b1;
                    r_state <= S_OWT;
                end
                S_OWT: begin
                    if (!i_out_stall) begin
                        r_out_valid <= 1'b0;
                        if (s_last) begin
                            r_ecnt <= '0;
                            r_qcnt <= '0;
                            r_wl <= '0;
                            r_wr <= '0;
                            r_sum <= '0;
                            r_state <= S_LOAD;
                        end else begin
                            r_q <= r_q + 1'b1;
                            r_state <= S_ORD;
                        end
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out = r_out;

endmodule
